[src/imte_pkg.sv]
package imte_pkg;

    // Command codes carried in the func field of an input item.
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_PUSH  = 3'd1;
    localparam logic [2:0] FUNC_WRITE = 3'd2;
    localparam logic [2:0] FUNC_READ  = 3'd3;
    localparam logic [2:0] FUNC_PROBE = 3'd4;

    // Completion status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ADDR_NACK = 3'd1;
    localparam logic [2:0] ST_REG_NACK  = 3'd2;
    localparam logic [2:0] ST_DATA_NACK = 3'd3;
    localparam logic [2:0] ST_BUS_BUSY  = 3'd4;

    // Register address modes.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_ONE    = 2'd1;
    localparam logic [1:0] MODE_TWO    = 2'd2;
    localparam logic [1:0] MODE_FOLDED = 2'd3;

    localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd250;

    typedef struct packed {
        logic [2:0]  func;
        logic        sda_in;
        logic        scl_in;
        logic [1:0]  addr_mode;
        logic [7:0]  device_address;
        logic [15:0] register_address;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       accepted;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] status;
    } t_out_item;

endpackage

[src/imte_if.sv]
// Input item channel.
interface imte_in_if;
    logic                valid;
    logic                ready;
    imte_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result item channel.
interface imte_out_if;
    logic                valid;
    logic                ready;
    imte_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel for the acknowledge timeout.
interface imte_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/i2c_master_transaction_engine_core.sv]
// I2C master sequencer stepped by tick items, each one microsecond of bus time.
// Every input item (tick, buffer push, or write/read/probe start) yields exactly
// one result item carrying the SCL/SDA drive levels, command acceptance, busy,
// a received byte and completion status. An item is accepted in every cycle
// while the result register is empty or being drained: the whole step, up to
// two chained sequencer actions, runs as one combinational pass between the
// accepted item and the result register, so throughput is one item per clock.
// Write data is staged in a WRITE_DEPTH-byte buffer that empties when a write
// transaction ends. The acknowledge timeout register may be written while idle.
module i2c_master_transaction_engine_core #(
    parameter int WRITE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    imte_in_if.sink        i_in,
    imte_out_if.source     o_out,
    imte_cfg_if.sink       i_cfg
);

    localparam int PW = $clog2(WRITE_DEPTH + 1);
    localparam int IW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START1, PH_ADDR_W, PH_REG_HI, PH_REG_LO,
        PH_WDATA, PH_START2, PH_ADDR_R, PH_RDATA, PH_STOP
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  micro;
        logic [2:0]  seg;
        logic [3:0]  bitc;
        logic [7:0]  shreg;
        logic [9:0]  tickc;
        logic [15:0] remain;
        logic [PW-1:0] wpos;
        logic [PW-1:0] fill;
        logic [1:0]  mode;
        logic [7:0]  dev;
        logic [15:0] rega;
        logic        is_read;
        logic        is_probe;
        logic [2:0]  stat;
        logic        scl;
        logic        sda;
        logic        rvalid;
        logic [7:0]  rbyte;
        logic        done;
        logic [2:0]  dstat;
    } t_st;

    t_st r_st, n_st, s1, s2;
    logic [7:0] r_buf [WRITE_DEPTH];
    logic [9:0] r_timeout;
    logic       r_out_valid;
    imte_pkg::t_out_item r_out, n_out;
    logic       in_fire;
    logic       acc;
    imte_pkg::t_in_item it;

    assign it      = i_in.data;
    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Idle sequencer with both lines released.
    function automatic t_st reset_state();
        t_st o;
        o = '0;
        o.phase = PH_IDLE;
        o.scl = 1'b1;
        o.sda = 1'b1;
        return o;
    endfunction

    // Address byte with direction in bit 0; folded mode adds the high register bits.
    function automatic logic [7:0] addr_byte(input t_st s, input logic rd);
        logic [7:0] b;
        b = s.dev & 8'hFE;
        if (s.mode == imte_pkg::MODE_FOLDED) begin
            b = b + {s.rega[14:8], 1'b0};
        end
        return {b[7:1], rd};
    endfunction

    function automatic t_st begin_op(input t_st s, input t_phase p, input logic [7:0] b);
        t_st o;
        o = s;
        o.phase = p;
        o.micro = 3'd0;
        o.shreg = b;
        return o;
    endfunction

    // Choose the next byte stage once addressing is done.
    function automatic t_st data_stage(input t_st s);
        if (s.is_read) begin
            return begin_op(s, PH_START2, 8'd0);
        end else if (s.remain != 16'd0 && s.wpos < PW'(WRITE_DEPTH)) begin
            return begin_op(s, PH_WDATA, r_buf[s.wpos[IW-1:0]]);
        end else begin
            return begin_op(s, PH_STOP, 8'd0);
        end
    endfunction

    function automatic t_st finish_op(input t_st s);
        t_st o;
        o = s;
        case (s.phase)
            PH_START1: begin
                if (s.is_read && s.mode == imte_pkg::MODE_NONE) begin
                    o = begin_op(s, PH_ADDR_R, addr_byte(s, 1'b1));
                end else begin
                    o = begin_op(s, PH_ADDR_W, addr_byte(s, 1'b0));
                end
            end
            PH_ADDR_W: begin
                if (s.is_probe) begin
                    o = begin_op(s, PH_STOP, 8'd0);
                end else if (s.mode == imte_pkg::MODE_TWO) begin
                    o = begin_op(s, PH_REG_HI, s.rega[15:8]);
                end else if (s.mode != imte_pkg::MODE_NONE) begin
                    o = begin_op(s, PH_REG_LO, s.rega[7:0]);
                end else begin
                    o = data_stage(s);
                end
            end
            PH_REG_HI: o = begin_op(s, PH_REG_LO, s.rega[7:0]);
            PH_REG_LO: o = data_stage(s);
            PH_WDATA: begin
                o.wpos = s.wpos + PW'(1);
                if (s.remain != 16'd0) begin
                    o.remain = s.remain - 16'd1;
                end
                o = data_stage(o);
            end
            PH_START2: o = begin_op(s, PH_ADDR_R, addr_byte(s, 1'b1));
            PH_ADDR_R: o = begin_op(s, PH_RDATA, 8'd0);
            PH_RDATA: begin
                if (s.remain != 16'd0) begin
                    o.remain = s.remain - 16'd1;
                end
                o = begin_op(o, (o.remain != 16'd0) ? PH_RDATA : PH_STOP, 8'd0);
            end
            default: o = begin_op(s, PH_STOP, 8'd0);
        endcase
        return o;
    endfunction

    // One sequencer action of the current phase and sub-step.
    function automatic t_st act(input t_st s, input logic sda);
        t_st o;
        logic last;
        o = s;
        last = (s.remain <= 16'd1);
        case (s.phase)
            PH_START1, PH_START2: begin
                case (s.micro)
                    3'd0: begin o.sda = 1'b1; o.scl = 1'b1; o.seg = 3'd4; o.micro = 3'd1; end
                    3'd1: begin o.sda = 1'b0; o.seg = 3'd4; o.micro = 3'd2; end
                    3'd2: begin o.scl = 1'b0; o.seg = 3'd4; o.micro = 3'd3; end
                    default: o = finish_op(s);
                endcase
            end
            PH_RDATA: begin
                case (s.micro)
                    3'd0: begin
                        o.sda = 1'b1; o.bitc = 4'd0; o.shreg = 8'd0;
                        o.seg = 3'd2; o.micro = 3'd1;
                    end
                    3'd1: begin
                        o.scl = 1'b1;
                        o.shreg = {s.shreg[6:0], sda};
                        if (s.bitc == 4'd7) begin
                            o.rvalid = 1'b1;
                            o.rbyte  = {s.shreg[6:0], sda};
                        end
                        o.seg = 3'd2; o.micro = 3'd2;
                    end
                    3'd2: begin
                        o.scl = 1'b0;
                        o.bitc = s.bitc + 4'd1;
                        if (o.bitc < 4'd8) begin
                            o.seg = 3'd2; o.micro = 3'd1;
                        end else begin
                            o.micro = 3'd3;
                        end
                    end
                    3'd3: begin
                        o.scl = 1'b0; o.sda = last; o.seg = 3'd2; o.micro = 3'd4;
                    end
                    3'd4: begin o.scl = 1'b1; o.seg = 3'd2; o.micro = 3'd5; end
                    3'd5: begin
                        o.scl = 1'b0; o.seg = last ? 3'd1 : 3'd2; o.micro = 3'd6;
                    end
                    default: begin
                        o.sda = 1'b1;
                        o = finish_op(o);
                    end
                endcase
            end
            PH_STOP: begin
                case (s.micro)
                    3'd0: begin o.sda = 1'b0; o.seg = 3'd1; o.micro = 3'd1; end
                    3'd1: begin o.scl = 1'b1; o.seg = 3'd4; o.micro = 3'd2; end
                    3'd2: begin o.sda = 1'b1; o.seg = 3'd4; o.micro = 3'd3; end
                    default: begin
                        o.done = 1'b1;
                        o.dstat = s.stat;
                        if (!s.is_read && !s.is_probe) begin
                            o.fill = '0;
                        end
                        o.phase = PH_IDLE; o.micro = 3'd0; o.seg = 3'd0;
                    end
                endcase
            end
            default: begin
                case (s.micro)
                    3'd0: begin o.scl = 1'b0; o.bitc = 4'd0; o.seg = 3'd1; o.micro = 3'd1; end
                    3'd1: begin
                        o.sda = s.shreg[7];
                        o.shreg = {s.shreg[6:0], 1'b0};
                        o.seg = 3'd1; o.micro = 3'd2;
                    end
                    3'd2: begin o.scl = 1'b1; o.seg = 3'd2; o.micro = 3'd3; end
                    3'd3: begin
                        o.scl = 1'b0; o.seg = 3'd1;
                        o.bitc = s.bitc + 4'd1;
                        o.micro = (o.bitc < 4'd8) ? 3'd1 : 3'd4;
                    end
                    3'd4: begin o.sda = 1'b1; o.seg = 3'd1; o.micro = 3'd5; end
                    3'd5: begin
                        o.scl = 1'b1; o.tickc = 10'd0; o.seg = 3'd1; o.micro = 3'd6;
                    end
                    3'd6: begin
                        if (!sda) begin
                            o.scl = 1'b0; o.seg = 3'd1; o.micro = 3'd7;
                        end else if (s.tickc >= r_timeout) begin
                            if (s.phase == PH_ADDR_W) begin
                                o.stat = imte_pkg::ST_ADDR_NACK;
                            end else if (s.phase == PH_REG_HI || s.phase == PH_REG_LO) begin
                                o.stat = imte_pkg::ST_REG_NACK;
                            end else begin
                                o.stat = imte_pkg::ST_DATA_NACK;
                            end
                            o = begin_op(o, PH_STOP, 8'd0);
                        end else begin
                            o.tickc = s.tickc + 10'd1; o.seg = 3'd1;
                        end
                    end
                    default: o = finish_op(s);
                endcase
            end
        endcase
        return o;
    endfunction

    function automatic t_st launch(input t_st s, input logic rd, input logic pr,
                                   input logic [1:0] m, input logic [7:0] d,
                                   input logic [15:0] r);
        t_st o;
        o = s;
        o.mode = m; o.dev = d; o.rega = r;
        o.is_read = rd; o.is_probe = pr;
        o.wpos = '0; o.stat = imte_pkg::ST_OK; o.tickc = 10'd0; o.bitc = 4'd0;
        o.phase = PH_START1; o.micro = 3'd0; o.seg = 3'd1;
        return o;
    endfunction

    // Step the sequencer, or apply a command, for the item being accepted.
    always_comb begin
        s1 = r_st;
        s1.rvalid = 1'b0; s1.rbyte = 8'd0; s1.done = 1'b0; s1.dstat = imte_pkg::ST_OK;
        s2 = s1;
        n_st = s1;
        acc = 1'b0;
        case (it.func)
            imte_pkg::FUNC_TICK: begin
                if (s1.phase != PH_IDLE) begin
                    if (s1.seg != 3'd0) begin
                        s1.seg = s1.seg - 3'd1;
                    end
                    s2 = s1;
                    if (s1.seg == 3'd0) begin
                        s2 = act(s1, it.sda_in);
                    end
                    n_st = s2;
                    if (s2.phase != PH_IDLE && s2.seg == 3'd0) begin
                        n_st = act(s2, it.sda_in);
                    end
                end
            end
            imte_pkg::FUNC_PUSH: begin
                if (s1.phase == PH_IDLE && s1.fill < PW'(WRITE_DEPTH)) begin
                    n_st.fill = s1.fill + PW'(1);
                    acc = 1'b1;
                end
            end
            imte_pkg::FUNC_WRITE: begin
                if (s1.phase == PH_IDLE) begin
                    n_st = launch(s1, 1'b0, 1'b0, it.addr_mode, it.device_address,
                                  it.register_address);
                    n_st.remain = (it.byte_count < 16'(s1.fill)) ? it.byte_count
                                                                 : 16'(s1.fill);
                    acc = 1'b1;
                end
            end
            imte_pkg::FUNC_READ: begin
                if (s1.phase == PH_IDLE) begin
                    n_st = launch(s1, 1'b1, 1'b0, it.addr_mode, it.device_address,
                                  it.register_address);
                    n_st.remain = (it.byte_count != 16'd0) ? it.byte_count : 16'd1;
                    acc = 1'b1;
                end
            end
            imte_pkg::FUNC_PROBE: begin
                if (s1.phase == PH_IDLE) begin
                    acc = 1'b1;
                    if (it.sda_in && it.scl_in) begin
                        n_st = launch(s1, 1'b0, 1'b1, imte_pkg::MODE_NONE,
                                      it.device_address, 16'd0);
                        n_st.remain = 16'd0;
                    end else begin
                        n_st.done  = 1'b1;
                        n_st.dstat = imte_pkg::ST_BUS_BUSY;
                    end
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    // Result item fields.
    always_comb begin
        n_out.scl_level  = n_st.scl;
        n_out.sda_level  = n_st.sda;
        n_out.accepted   = acc;
        n_out.busy_res   = (n_st.phase != PH_IDLE);
        n_out.read_valid = n_st.rvalid;
        n_out.read_byte  = n_st.rvalid ? n_st.rbyte : 8'd0;
        n_out.done_res   = n_st.done;
        n_out.status     = n_st.done ? n_st.dstat : imte_pkg::ST_OK;
    end

    // Sequencer state, result register and timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= reset_state();
            r_out_valid <= 1'b0;
            r_timeout   <= imte_pkg::ACK_TIMEOUT_RESET;
        end else begin
            if (in_fire) begin
                r_st        <= n_st;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    // Write buffer, filled by push items.
    always_ff @(posedge i_clk) begin
        if (in_fire && acc && it.func == imte_pkg::FUNC_PUSH) begin
            r_buf[r_st.fill[IW-1:0]] <= it.write_byte;
        end
    end

endmodule

[bench/tb_i2c_master_transaction_engine_core.sv]
module tb_i2c_master_transaction_engine_core;
    import imte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WBUF_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1150;
    localparam int PHASE_MIN   = 100;

    // Sequencer phases of the bus engine.
    typedef enum logic [3:0] {
        BP_IDLE, BP_START1, BP_ADDR_W, BP_REG_HI, BP_REG_LO,
        BP_WDATA, BP_START2, BP_ADDR_R, BP_RDATA, BP_STOP
    } t_bus_phase;

    // One row of the directed stimulus.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
        bit        drain;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    imte_in_if  in_ch ();
    imte_out_if out_ch ();
    imte_cfg_if cfg_ch ();

    i2c_master_transaction_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Engine shadow state.
    logic [9:0]  ack_limit;
    t_bus_phase  bus_ph;
    int          micro;
    int          seg_left;
    int          ack_wait;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  wbuf [WBUF_DEPTH];
    int          wfill;
    int          wpos;
    logic [15:0] bytes_left;
    logic [1:0]  hold_mode;
    logic [7:0]  hold_dev;
    logic [15:0] hold_reg;
    logic        is_rd;
    logic        is_probe;
    logic        scl_o;
    logic        sda_o;
    logic [2:0]  end_status;
    logic        got_byte;
    logic [7:0]  rx_byte;
    logic        got_done;
    logic [2:0]  done_status;

    t_out_item exp_results[$];
    int        errors = 0;
    int        items_sent = 0;
    int        cycles = 0;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;
    bit        hold_req = 1'b0;
    int        hold_left = 0;
    int        sda_high_pct = 20;

    function automatic logic [7:0] bus_address(logic rd);
        logic [8:0] b;
        b = {1'b0, hold_dev[7:1], 1'b0};
        if (hold_mode == MODE_FOLDED) begin
            b = b + {hold_reg[15:8], 1'b0};
        end
        return {b[7:1], rd};
    endfunction

    function automatic void begin_seg(t_bus_phase p, logic [7:0] b);
        bus_ph = p;
        micro  = 0;
        shreg  = b;
    endfunction

    function automatic void data_stage();
        if (is_rd) begin
            begin_seg(BP_START2, 8'h00);
        end else if (bytes_left != 0 && wpos < WBUF_DEPTH) begin
            begin_seg(BP_WDATA, wbuf[wpos]);
        end else begin
            begin_seg(BP_STOP, 8'h00);
        end
    endfunction

    // Pick the segment that follows a completed one.
    function automatic void next_seg();
        case (bus_ph)
            BP_START1: begin
                if (is_rd && hold_mode == MODE_NONE) begin
                    begin_seg(BP_ADDR_R, bus_address(1'b1));
                end else begin
                    begin_seg(BP_ADDR_W, bus_address(1'b0));
                end
            end
            BP_ADDR_W: begin
                if (is_probe) begin
                    begin_seg(BP_STOP, 8'h00);
                end else if (hold_mode == MODE_TWO) begin
                    begin_seg(BP_REG_HI, hold_reg[15:8]);
                end else if (hold_mode != MODE_NONE) begin
                    begin_seg(BP_REG_LO, hold_reg[7:0]);
                end else begin
                    data_stage();
                end
            end
            BP_REG_HI: begin_seg(BP_REG_LO, hold_reg[7:0]);
            BP_REG_LO: data_stage();
            BP_WDATA: begin
                wpos++;
                if (bytes_left != 0) bytes_left--;
                data_stage();
            end
            BP_START2: begin_seg(BP_ADDR_R, bus_address(1'b1));
            BP_ADDR_R: begin_seg(BP_RDATA, 8'h00);
            BP_RDATA: begin
                if (bytes_left != 0) bytes_left--;
                begin_seg((bytes_left != 0) ? BP_RDATA : BP_STOP, 8'h00);
            end
            default: begin_seg(BP_STOP, 8'h00);
        endcase
    endfunction

    function automatic void act_start();
        case (micro)
            0: begin sda_o = 1'b1; scl_o = 1'b1; seg_left = 4; micro = 1; end
            1: begin sda_o = 1'b0; seg_left = 4; micro = 2; end
            2: begin scl_o = 1'b0; seg_left = 4; micro = 3; end
            default: next_seg();
        endcase
    endfunction

    // Byte transmit followed by the acknowledge wait.
    function automatic void act_send(logic sda);
        case (micro)
            0: begin scl_o = 1'b0; bit_cnt = 4'd0; seg_left = 1; micro = 1; end
            1: begin
                sda_o = shreg[7];
                shreg = {shreg[6:0], 1'b0};
                seg_left = 1;
                micro = 2;
            end
            2: begin scl_o = 1'b1; seg_left = 2; micro = 3; end
            3: begin
                scl_o = 1'b0;
                seg_left = 1;
                bit_cnt = bit_cnt + 4'd1;
                micro = (bit_cnt < 8) ? 1 : 4;
            end
            4: begin sda_o = 1'b1; seg_left = 1; micro = 5; end
            5: begin scl_o = 1'b1; ack_wait = 0; seg_left = 1; micro = 6; end
            6: begin
                if (!sda) begin
                    scl_o = 1'b0;
                    seg_left = 1;
                    micro = 7;
                end else if (ack_wait >= ack_limit) begin
                    if (bus_ph == BP_ADDR_W) end_status = ST_ADDR_NACK;
                    else if (bus_ph == BP_REG_HI || bus_ph == BP_REG_LO) end_status = ST_REG_NACK;
                    else end_status = ST_DATA_NACK;
                    begin_seg(BP_STOP, 8'h00);
                end else begin
                    ack_wait++;
                    seg_left = 1;
                end
            end
            default: next_seg();
        endcase
    endfunction

    // Byte receive; the last byte of a read gets a NACK.
    function automatic void act_read(logic sda);
        logic last;
        last = (bytes_left <= 1);
        case (micro)
            0: begin
                sda_o = 1'b1; bit_cnt = 4'd0; shreg = 8'h00; seg_left = 2; micro = 1;
            end
            1: begin
                scl_o = 1'b1;
                shreg = {shreg[6:0], sda};
                if (bit_cnt == 7) begin
                    got_byte = 1'b1;
                    rx_byte = shreg;
                end
                seg_left = 2;
                micro = 2;
            end
            2: begin
                scl_o = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < 8) begin
                    seg_left = 2;
                    micro = 1;
                end else begin
                    micro = 3;
                end
            end
            3: begin scl_o = 1'b0; sda_o = last; seg_left = 2; micro = 4; end
            4: begin scl_o = 1'b1; seg_left = 2; micro = 5; end
            5: begin scl_o = 1'b0; seg_left = last ? 1 : 2; micro = 6; end
            default: begin sda_o = 1'b1; next_seg(); end
        endcase
    endfunction

    function automatic void act_stop();
        case (micro)
            0: begin sda_o = 1'b0; seg_left = 1; micro = 1; end
            1: begin scl_o = 1'b1; seg_left = 4; micro = 2; end
            2: begin sda_o = 1'b1; seg_left = 4; micro = 3; end
            default: begin
                got_done = 1'b1;
                done_status = end_status;
                if (!is_rd && !is_probe) wfill = 0;
                bus_ph = BP_IDLE;
                micro = 0;
                seg_left = 0;
            end
        endcase
    endfunction

    function automatic void launch(logic rd, logic probe, logic [1:0] mode,
                                   logic [7:0] dev, logic [15:0] regaddr);
        hold_mode = mode;
        hold_dev = dev;
        hold_reg = regaddr;
        is_rd = rd;
        is_probe = probe;
        wpos = 0;
        end_status = ST_OK;
        ack_wait = 0;
        bit_cnt = 4'd0;
        bus_ph = BP_START1;
        micro = 0;
        seg_left = 1;
    endfunction

    function automatic void reset_engine();
        ack_limit = ACK_TIMEOUT_RESET;
        bus_ph = BP_IDLE;
        micro = 0;
        seg_left = 0;
        ack_wait = 0;
        bit_cnt = 4'd0;
        shreg = 8'h00;
        wfill = 0;
        wpos = 0;
        bytes_left = 16'd0;
        hold_mode = MODE_NONE;
        hold_dev = 8'h00;
        hold_reg = 16'h0000;
        is_rd = 1'b0;
        is_probe = 1'b0;
        scl_o = 1'b1;
        sda_o = 1'b1;
        end_status = ST_OK;
    endfunction

    // Advance the engine by one item and return the result it gives.
    function automatic t_out_item step_engine(t_in_item it);
        t_out_item r;
        logic      idle;
        logic      acc;
        int        guard;
        idle = (bus_ph == BP_IDLE);
        acc = 1'b0;
        got_byte = 1'b0;
        rx_byte = 8'h00;
        got_done = 1'b0;
        done_status = ST_OK;
        case (it.func)
            FUNC_TICK: begin
                if (!idle) begin
                    guard = 64;
                    if (seg_left > 0) seg_left--;
                    while (bus_ph != BP_IDLE && seg_left == 0 && guard > 0) begin
                        case (bus_ph)
                            BP_START1, BP_START2: act_start();
                            BP_RDATA: act_read(it.sda_in);
                            BP_STOP: act_stop();
                            default: act_send(it.sda_in);
                        endcase
                        guard--;
                    end
                end
            end
            FUNC_PUSH: begin
                if (idle && wfill < WBUF_DEPTH) begin
                    wbuf[wfill] = it.write_byte;
                    wfill++;
                    acc = 1'b1;
                end
            end
            FUNC_WRITE: begin
                if (idle) begin
                    launch(1'b0, 1'b0, it.addr_mode, it.device_address, it.register_address);
                    bytes_left = (it.byte_count < wfill) ? it.byte_count : 16'(wfill);
                    acc = 1'b1;
                end
            end
            FUNC_READ: begin
                if (idle) begin
                    launch(1'b1, 1'b0, it.addr_mode, it.device_address, it.register_address);
                    bytes_left = (it.byte_count != 0) ? it.byte_count : 16'd1;
                    acc = 1'b1;
                end
            end
            FUNC_PROBE: begin
                if (idle) begin
                    acc = 1'b1;
                    if (it.sda_in && it.scl_in) begin
                        launch(1'b0, 1'b1, MODE_NONE, it.device_address, 16'h0000);
                        bytes_left = 16'd0;
                    end else begin
                        got_done = 1'b1;
                        done_status = ST_BUS_BUSY;
                    end
                end
            end
            default: ;
        endcase
        r.scl_level = scl_o;
        r.sda_level = sda_o;
        r.accepted = acc;
        r.busy_res = (bus_ph != BP_IDLE);
        r.read_valid = got_byte;
        r.read_byte = got_byte ? rx_byte : 8'h00;
        r.done_res = got_done;
        r.status = got_done ? done_status : ST_OK;
        return r;
    endfunction

    function automatic t_in_item make_item(logic [2:0] f, logic sda, logic scl,
                                           logic [1:0] mode, logic [7:0] dev,
                                           logic [15:0] regaddr, logic [15:0] cnt,
                                           logic [7:0] wb);
        t_in_item it;
        it.func = f;
        it.sda_in = sda;
        it.scl_in = scl;
        it.addr_mode = mode;
        it.device_address = dev;
        it.register_address = regaddr;
        it.byte_count = cnt;
        it.write_byte = wb;
        return it;
    endfunction

    function automatic t_out_item make_result(logic acc, logic busy, logic done,
                                              logic [2:0] st);
        t_out_item r;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.accepted = acc;
        r.busy_res = busy;
        r.done_res = done;
        r.status = st;
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then record what it should give.
    // Called right after a rising edge.
    task automatic send_item(t_in_item it, bit typed = 1'b0, t_out_item want = '0);
        t_out_item r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        r = step_engine(it);
        exp_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    function automatic t_in_item tick_item();
        return make_item(FUNC_TICK, ($urandom_range(0, 99) < sda_high_pct),
                         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    // Tick the bus until the engine is idle, with an occasional stray command.
    task automatic run_to_idle();
        t_in_item it;
        while (bus_ph != BP_IDLE) begin
            it = tick_item();
            if ($urandom_range(0, 99) < 3) it.func = 3'($urandom_range(1, 7));
            send_item(it);
        end
    endtask

    // Stop offering items and let every expected result come out.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (exp_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [9:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        ack_limit = value;
    endtask

    // One bus transaction: some buffer pushes, a command, then ticks to the end.
    task automatic run_transaction();
        t_in_item it;
        int       npush;
        int       pick;
        npush = ($urandom_range(0, 9) == 0) ? 17 : int'($urandom_range(0, 3));
        pick = int'($urandom_range(0, 3));
        sda_high_pct = (pick == 0) ? 5 : (pick == 1) ? 25 : (pick == 2) ? 50 : 100;
        if (sda_high_pct == 100 && ack_limit > 20) sda_high_pct = 50;
        for (int i = 0; i < npush; i++) begin
            send_item(make_item(FUNC_PUSH, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                8'($urandom), 16'($urandom), 16'($urandom),
                                8'($urandom)));
        end
        it = tick_item();
        pick = int'($urandom_range(0, 19));
        if (pick < 8) begin
            it.func = FUNC_WRITE;
            if ($urandom_range(0, 1) != 0) it.byte_count = 16'($urandom_range(0, 4));
        end else if (pick < 16) begin
            it.func = FUNC_READ;
            it.byte_count = 16'($urandom_range(0, 2));
        end else if (pick < 19) begin
            it.func = FUNC_PROBE;
            it.sda_in = ($urandom_range(0, 99) < 85) ? 1'b1 : 1'($urandom_range(0, 1));
            it.scl_in = ($urandom_range(0, 99) < 85) ? 1'b1 : 1'($urandom_range(0, 1));
        end else begin
            it.func = 3'($urandom_range(5, 7));
        end
        send_item(it);
        run_to_idle();
        // Ticks on an idle bus.
        repeat ($urandom_range(0, 2)) send_item(tick_item());
    endtask

    // Directed stimulus table.
    t_stim_row rows[$];
    task automatic add_row(t_in_item it, bit typed, t_out_item want, bit drain);
        t_stim_row row;
        row.item = it;
        row.typed = typed;
        row.want = want;
        row.drain = drain;
        rows.push_back(row);
    endtask

    // Receiver: random stalls and, on request, one long hold-off.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (exp_results.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = exp_results.pop_front();
                check_field("scl_level", int'(want.scl_level), int'(got.scl_level));
                check_field("sda_level", int'(want.sda_level), int'(got.sda_level));
                check_field("accepted", int'(want.accepted), int'(got.accepted));
                check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
                check_field("read_valid", int'(want.read_valid), int'(got.read_valid));
                check_field("read_byte", int'(want.read_byte), int'(got.read_byte));
                check_field("done_res", int'(want.done_res), int'(got.done_res));
                check_field("status", int'(want.status), int'(got.status));
            end
        end
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int target;
        int budget;
        reset_engine();
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset levels, buffer pushes, ignored codes, busy-bus probes.
        add_row(make_item(FUNC_TICK, 1'b1, 1'b1, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'h00),
                1'b1, make_result(1'b0, 1'b0, 1'b0, ST_OK), 1'b0);
        add_row(make_item(FUNC_PUSH, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'hFF),
                1'b1, make_result(1'b1, 1'b0, 1'b0, ST_OK), 1'b0);
        add_row(make_item(FUNC_PUSH, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'h00),
                1'b1, make_result(1'b1, 1'b0, 1'b0, ST_OK), 1'b0);
        add_row(make_item(3'd5, 1'b1, 1'b1, MODE_FOLDED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF),
                1'b1, make_result(1'b0, 1'b0, 1'b0, ST_OK), 1'b0);
        add_row(make_item(3'd7, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'h00),
                1'b1, make_result(1'b0, 1'b0, 1'b0, ST_OK), 1'b0);
        add_row(make_item(FUNC_PROBE, 1'b0, 1'b1, MODE_NONE, 8'hA0, 16'h0, 16'h0, 8'h00),
                1'b1, make_result(1'b1, 1'b0, 1'b1, ST_BUS_BUSY), 1'b0);
        add_row(make_item(FUNC_PROBE, 1'b1, 1'b0, MODE_NONE, 8'hA0, 16'h0, 16'h0, 8'h00),
                1'b1, make_result(1'b1, 1'b0, 1'b1, ST_BUS_BUSY), 1'b0);
        // Folded address with every address bit set; count clamps to the fill.
        add_row(make_item(FUNC_WRITE, 1'b1, 1'b1, MODE_FOLDED, 8'hFF, 16'hFFFF, 16'hFFFF,
                          8'h00),
                1'b1, make_result(1'b1, 1'b1, 1'b0, ST_OK), 1'b1);
        // Empty buffer write, then reads in every mode, count zero among them.
        add_row(make_item(FUNC_WRITE, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_READ, 1'b0, 1'b0, MODE_NONE, 8'h55, 16'h0, 16'h0, 8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_READ, 1'b0, 1'b0, MODE_ONE, 8'hAA, 16'h00FF, 16'd2, 8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_READ, 1'b0, 1'b0, MODE_TWO, 8'h12, 16'hFF00, 16'd1, 8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_READ, 1'b0, 1'b0, MODE_FOLDED, 8'hFE, 16'h7F00, 16'd1,
                          8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_PUSH, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'hAA),
                1'b0, '0, 1'b0);
        add_row(make_item(FUNC_PUSH, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'h55),
                1'b0, '0, 1'b0);
        add_row(make_item(FUNC_WRITE, 1'b0, 1'b0, MODE_TWO, 8'h50, 16'h1234, 16'd1, 8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_PUSH, 1'b0, 1'b0, MODE_NONE, 8'h00, 16'h0, 16'h0, 8'h3C),
                1'b0, '0, 1'b0);
        add_row(make_item(FUNC_WRITE, 1'b0, 1'b0, MODE_ONE, 8'h51, 16'h00C3, 16'd5, 8'h00),
                1'b0, '0, 1'b1);
        add_row(make_item(FUNC_PROBE, 1'b1, 1'b1, MODE_NONE, 8'hA1, 16'h0, 16'h0, 8'h00),
                1'b0, '0, 1'b1);

        foreach (rows[i]) begin
            send_item(rows[i].item, rows[i].typed, rows[i].want);
            if (rows[i].drain) run_to_idle();
        end

        // Random transactions under three idling patterns, sharing what is left
        // of the item budget.
        for (int p = 0; p < 3; p++) begin
            write_timeout((p == 0) ? 10'd1 : (p == 1) ? 10'd1023 : 10'd0);
            src_idle_pct = (p == 0) ? 17 : (p == 1) ? 87 : 0;
            sink_idle_pct = (p == 0) ? 87 : (p == 1) ? 17 : 0;
            if (p == 2) hold_req = 1'b1;
            budget = (ITEM_TARGET - items_sent) / (3 - p);
            if (budget < PHASE_MIN) budget = PHASE_MIN;
            target = items_sent + budget;
            while (items_sent < target) begin
                run_transaction();
                if ($urandom_range(0, 9) == 0) write_timeout(10'($urandom_range(0, 40)));
            end
        end

        drain_results();
        if (errors == 0 && exp_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
